/* rtl/core/pls_pkg.sv */
// ----------------------------------------------------------------------------
// pls_pkg
// Shared constants for the piecewise linear stretch.
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int DN_BITS_DEF    = 16;
    localparam int NORM_BITS      = 17;
    localparam int IDX_BITS       = 4;
    localparam int SAMPLE_BITS    = 16;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [NORM_BITS-1:0] NORM_ONE = 17'd65536;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_EN  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_THR = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_EN = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_THR = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_LO = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_HI = 3'd5;

    // item kinds
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_CONVERT = 1'b1;

endpackage

/* rtl/core/pls_cell.sv */
// ----------------------------------------------------------------------------
// pls_cell
// One breakpoint slot of the table. Holds its point and, when shifted, takes
// the point of its neighbour along the ring so the sequencer sees every slot.
// ----------------------------------------------------------------------------
module pls_cell
    import pls_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [NORM_BITS-1:0] i_reset_x,
    input  logic [NORM_BITS-1:0] i_reset_y,
    input  logic                 i_load,
    input  logic [NORM_BITS-1:0] i_load_x,
    input  logic [NORM_BITS-1:0] i_load_y,
    input  logic                 i_shift,
    input  logic [NORM_BITS-1:0] i_prev_x,
    input  logic [NORM_BITS-1:0] i_prev_y,
    output logic [NORM_BITS-1:0] o_x,
    output logic [NORM_BITS-1:0] o_y
);

    logic [NORM_BITS-1:0] r_x, r_y;

    // load a new point, or rotate with the neighbour
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= i_reset_x;
            r_y <= i_reset_y;
        end else if (i_load) begin
            r_x <= i_load_x;
            r_y <= i_load_y;
        end else if (i_shift) begin
            r_x <= i_prev_x;
            r_y <= i_prev_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

/* rtl/core/pls_divider.sv */
// ----------------------------------------------------------------------------
// pls_divider
// Restoring divider for unsigned magnitudes, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pls_divider #(
    parameter int NUM_BITS = 40,
    parameter int DEN_BITS = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic                o_done,
    output logic [NUM_BITS-1:0] o_quot
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_quot;
    logic [DEN_BITS:0]   r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy, r_done;
    logic [DEN_BITS:0]   n_rem;
    logic [DEN_BITS+1:0] n_trial;

    // trial subtract one bit wider than the partial remainder, top bit is the borrow
    always_comb begin
        n_rem   = {r_rem[DEN_BITS-1:0], r_quot[NUM_BITS-1]};
        n_trial = {1'b0, n_rem} - {2'b00, r_den};
    end

    // shift in one numerator bit, subtract where it fits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(NUM_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (!n_trial[DEN_BITS+1]) begin
                r_rem  <= n_trial[DEN_BITS:0];
                r_quot <= {r_quot[NUM_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= n_rem;
                r_quot <= {r_quot[NUM_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* rtl/core/piecewise_linear_stretch.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_stretch
// Stretches DN samples through a loaded table of normalized breakpoints.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  input   | in        | i_valid / o_stall    | kind, point_index, point_x/y,
//          |           |                      | final_point, sample
//  output  | out       | o_valid / i_stall    | stretched, masked, passed_through
//  config  | in        | i_cfg_we             | i_cfg_index, i_cfg_data
//
// A load is written into its cell when it is accepted. A masked convert has
// its result registered in the cycle after it is accepted. Otherwise the ring
// is scanned slot by slot through the MUL, MAPB and SCAN states, and a
// pass-through or zero-width result follows the scan; an interpolated one
// adds a product, the divider and a register stage. Reset restores the
// default two-point identity table and clears the configuration and sequencer
// registers. The input is stalled while a convert runs or a result waits.
// ----------------------------------------------------------------------------
module piecewise_linear_stretch
    import pls_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int DN_BITS    = DN_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_kind,
    input  logic [IDX_BITS-1:0]      i_point_index,
    input  logic [NORM_BITS-1:0]     i_point_x,
    input  logic [NORM_BITS-1:0]     i_point_y,
    input  logic                     i_final_point,
    input  logic [SAMPLE_BITS-1:0]   i_sample,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [SAMPLE_BITS-1:0]   o_stretched,
    output logic                     o_masked,
    output logic                     o_passed_through
);

    localparam int CB   = $clog2(MAX_POINTS + 1);
    localparam int DW   = DN_BITS + 2;              // signed DN-domain width
    localparam int MW   = NORM_BITS + DN_BITS + 1;  // product width
    localparam int NUMW = 2 * DW;                   // division numerator
    localparam int DENW = DW;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_MAPB = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    // ------------------------------------------------------------------
    // configuration registers
    logic                   r_left_en, r_right_en;
    logic [SAMPLE_BITS-1:0] r_left_thr, r_right_thr, r_lo16, r_hi16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_en <= 1'b0; r_left_thr <= '0;
            r_right_en <= 1'b0; r_right_thr <= '0;
            r_lo16 <= '0; r_hi16 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LEFT_EN:   r_left_en   <= i_cfg_data[0];
                REG_LEFT_THR:  r_left_thr  <= i_cfg_data;
                REG_RIGHT_EN:  r_right_en  <= i_cfg_data[0];
                REG_RIGHT_THR: r_right_thr <= i_cfg_data;
                REG_RANGE_LO:  r_lo16      <= i_cfg_data;
                REG_RANGE_HI:  r_hi16      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // control registers
    logic [2:0]  r_state;
    logic [CB-1:0] r_count;
    logic [CB-1:0] r_step;
    logic          r_found, r_first;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic          r_ovalid, r_omask, r_opass;
    logic [SAMPLE_BITS-1:0] r_ostr;

    // range and held sample in DN domain, masked to DN_BITS
    logic signed [DW-1:0] w_lo, w_hi, w_span, w_s;
    always_comb begin
        w_lo = '0; w_hi = '0; w_s = '0;
        for (int b = 0; b < DN_BITS && b < SAMPLE_BITS; b++) begin
            w_lo[b] = r_lo16[b];
            w_hi[b] = r_hi16[b];
            w_s[b]  = r_sample[b];
        end
        w_span = w_hi - w_lo;
    end

    // ring of cells; cell 0 is the head seen by the scanner
    logic [NORM_BITS-1:0] w_cx [MAX_POINTS];
    logic [NORM_BITS-1:0] w_cy [MAX_POINTS];
    logic                 w_shift;
    logic                 w_in_acc;
    logic [IDX_BITS:0]    w_ld_idx;

    assign w_in_acc = i_valid && !o_stall;
    assign w_shift  = (r_state == ST_SCAN);
    assign w_ld_idx = {1'b0, i_point_index};

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        pls_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_reset_x((g == 1) ? NORM_ONE : '0),
            .i_reset_y((g == 1) ? NORM_ONE : '0),
            .i_load   (w_in_acc && i_kind == KIND_LOAD &&
                       int'(w_ld_idx) == g),
            .i_load_x (i_point_x),
            .i_load_y (i_point_y),
            .i_shift  (w_shift),
            .i_prev_x (w_cx[(g + 1) % MAX_POINTS]),
            .i_prev_y (w_cy[(g + 1) % MAX_POINTS]),
            .o_x      (w_cx[g]),
            .o_y      (w_cy[g])
        );
    end

    // ------------------------------------------------------------------
    // map head point to DN: one multiply per coordinate, registered
    logic signed [DW-1:0] w_map_x, w_map_y;
    logic signed [DW-1:0] r_prev_x, r_prev_y;
    logic signed [DW-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [MW-1:0] r_px, r_py;

    // truncating shift toward zero of a signed product by 16
    function automatic logic signed [DW-1:0] f_div_norm(
        input logic signed [MW-1:0] p
    );
        logic signed [MW-1:0] a;
        a = p[MW-1] ? (p + MW'(65535)) : p;
        return DW'(a >>> 16);
    endfunction

    assign w_map_x = w_lo + f_div_norm(r_px);
    assign w_map_y = w_lo + f_div_norm(r_py);

    // ------------------------------------------------------------------
    // interpolation operands
    logic signed [DW-1:0] r_dy, r_ds, r_dx;
    logic signed [NUMW-1:0] r_numer;
    logic                 r_neg;
    logic                 w_div_done;
    logic [NUMW-1:0]      w_quot;
    logic                 r_div_go;
    logic [NUMW-1:0]      w_num_mag;
    logic [DENW-1:0]      w_den_mag;

    assign w_num_mag = r_numer[NUMW-1] ? NUMW'(-r_numer) : NUMW'(r_numer);
    assign w_den_mag = r_dx[DW-1] ? DENW'(-r_dx) : DENW'(r_dx);

    pls_divider #(.NUM_BITS(NUMW), .DEN_BITS(DENW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_div_go),
        .i_num  (w_num_mag),
        .i_den  (w_den_mag),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    logic signed [NUMW-1:0] w_q_s, w_v;
    logic signed [DW-1:0]   w_clamp;
    always_comb begin
        w_q_s = r_neg ? -$signed(w_quot) : $signed(w_quot);
        w_v   = NUMW'(r_ay) + w_q_s;
        if (w_v < NUMW'(w_lo)) w_v = NUMW'(w_lo);
        if (w_v > NUMW'(w_hi)) w_v = NUMW'(w_hi);
        w_clamp = DW'(w_v);
    end

    logic signed [DW-1:0] w_by_clamp;
    always_comb begin
        w_by_clamp = r_by;
        if (w_by_clamp < w_lo) w_by_clamp = w_lo;
        if (w_by_clamp > w_hi) w_by_clamp = w_hi;
    end

    logic w_mask;
    assign w_mask = (r_left_en && i_sample <= r_left_thr) ||
                    (r_right_en && i_sample >= r_right_thr);

    // ------------------------------------------------------------------
    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= CB'(2);
            r_ovalid <= 1'b0;
            r_div_go <= 1'b0;
            r_step   <= '0;
            r_found  <= 1'b0;
            r_first  <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (i_kind == KIND_LOAD) begin
                            if (i_final_point && int'(w_ld_idx) < MAX_POINTS)
                                r_count <= CB'(w_ld_idx + 1'b1);
                        end else if (w_mask) begin
                            r_ovalid <= 1'b1;
                            r_omask  <= 1'b1;
                            r_opass  <= 1'b0;
                            r_ostr   <= SAMPLE_BITS'(w_lo);
                        end else begin
                            r_sample <= i_sample;
                            r_step   <= '0;
                            r_found  <= 1'b0;
                            r_first  <= 1'b1;
                            r_state  <= ST_MUL;
                        end
                    end
                end
                // products for the head cell
                ST_MUL: begin
                    r_px    <= MW'($signed({1'b0, w_cx[0]})) * MW'(w_span);
                    r_py    <= MW'($signed({1'b0, w_cy[0]})) * MW'(w_span);
                    r_state <= ST_MAPB;
                end
                // test segment (prev, head), then rotate the ring
                ST_MAPB: begin
                    r_prev_x <= w_map_x;
                    r_prev_y <= w_map_y;
                    r_step   <= r_step + 1'b1;
                    if (r_step != '0 && !r_found && r_step < r_count &&
                        w_s >= r_prev_x && (w_s < w_map_x || (r_step + 1'b1) == r_count)) begin
                        r_found <= 1'b1;
                        r_ax <= r_prev_x; r_ay <= r_prev_y;
                        r_bx <= w_map_x;  r_by <= w_map_y;
                    end
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (r_step == CB'(MAX_POINTS)) begin
                        r_state <= ST_DIV;
                        r_first <= 1'b1;
                    end else begin
                        r_state <= ST_MUL;
                    end
                end
                ST_DIV: begin
                    if (r_first) begin
                        r_first <= 1'b0;
                        if (!r_found) begin
                            r_ovalid <= 1'b1;
                            r_omask  <= 1'b0;
                            r_opass  <= 1'b1;
                            r_ostr   <= SAMPLE_BITS'(w_s);
                            r_state  <= ST_IDLE;
                        end else if (r_bx == r_ax) begin
                            r_ovalid <= 1'b1;
                            r_omask  <= 1'b0;
                            r_opass  <= 1'b0;
                            r_ostr   <= SAMPLE_BITS'(w_by_clamp);
                            r_state  <= ST_IDLE;
                        end else begin
                            r_dy <= r_by - r_ay;
                            r_ds <= w_s - r_ax;
                            r_dx <= r_bx - r_ax;
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_OUT: begin
                    // multiply once, then divide
                    if (!r_first) begin
                        r_numer  <= NUMW'(r_dy) * NUMW'(r_ds);
                        r_neg    <= r_dy[DW-1] ^ r_ds[DW-1] ^ r_dx[DW-1];
                        r_first  <= 1'b1;
                    end else if (r_step != '0) begin
                        r_div_go <= 1'b1;
                        r_step   <= '0;
                    end else if (w_div_done) begin
                        r_ovalid <= 1'b1;
                        r_omask  <= 1'b0;
                        r_opass  <= 1'b0;
                        r_ostr   <= SAMPLE_BITS'(w_clamp);
                        r_state  <= ST_IDLE;
                        r_first  <= 1'b0;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // the numerator sign is zero when the product is zero; a zero quotient is fine
    assign o_stall          = (r_state != ST_IDLE) || r_ovalid;
    assign o_valid          = r_ovalid;
    assign o_stretched      = r_ostr;
    assign o_masked         = r_omask;
    assign o_passed_through = r_opass;

endmodule
